FILE: rtl/core/nctm_pkg.sv
// ----------------------------------------------------------------------------
// nctm_pkg
// Shared types, widths and constants of the nearest centroid track matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package nctm_pkg;

  // Table size default
  localparam int MAX_TRACKS_DEF = 64;

  // Field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 11;
  localparam int AREA_W   = 23;
  localparam int LANE_W   = 3;
  localparam int IDX_W    = 6;
  localparam int DIST_W   = 20;
  localparam int CNT_W    = 7;
  localparam int GATE_W   = 6;
  localparam int SDIV_W   = 4;
  localparam int SQ_W     = 23;  // dx*dx + dy*dy
  localparam int GH_W     = 17;  // gate_quarters * box_height
  localparam int GHSQ_W   = 34;  // (gate_quarters * box_height)^2

  // Packed channel widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  // Configuration register indexes and reset values
  localparam logic CFG_GATE  = 1'b0;
  localparam logic CFG_SPEED = 1'b1;
  localparam logic [GATE_W-1:0] GATE_RST  = 6'd10;
  localparam logic [SDIV_W-1:0] SPEED_RST = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_SEED  = 2'd0,
    OP_MATCH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GATE,
    ST_CHECK,
    ST_UPDATE,
    ST_SQRT,
    ST_DIV,
    ST_INSERT,
    ST_DONE
  } state_t;

  // Write enables of the track memory
  typedef struct packed {
    logic pos_we;
    logic attr_we;
  } mem_we_t;

endpackage

`default_nettype wire

FILE: rtl/core/nctm_track_mem.sv
// ----------------------------------------------------------------------------
// nctm_track_mem
// Track table: position memory and attribute memory, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module nctm_track_mem #(
  parameter int MAX_TRACKS = nctm_pkg::MAX_TRACKS_DEF
) (
  input  wire                              clk,
  input  nctm_pkg::mem_we_t                we,
  input  wire [$clog2(MAX_TRACKS)-1:0]     wr_addr,
  input  wire [nctm_pkg::COORD_W-1:0]      wr_x,
  input  wire [nctm_pkg::COORD_W-1:0]      wr_y,
  input  wire [nctm_pkg::AREA_W-1:0]       wr_area,
  input  wire [nctm_pkg::LANE_W-1:0]       wr_lane,
  input  wire [$clog2(MAX_TRACKS)-1:0]     rd_addr,
  output logic [nctm_pkg::COORD_W-1:0]     rd_x,
  output logic [nctm_pkg::COORD_W-1:0]     rd_y,
  output logic [nctm_pkg::AREA_W-1:0]      rd_area,
  output logic [nctm_pkg::LANE_W-1:0]      rd_lane
);
  import nctm_pkg::*;

  localparam int POS_W  = 2 * COORD_W;
  localparam int ATTR_W = AREA_W + LANE_W;

  logic [POS_W-1:0]  pos_mem  [MAX_TRACKS];
  logic [ATTR_W-1:0] attr_mem [MAX_TRACKS];

  // Write ports
  always_ff @(posedge clk) begin
    if (we.pos_we) begin
      pos_mem[wr_addr] <= {wr_y, wr_x};
    end
    if (we.attr_we) begin
      attr_mem[wr_addr] <= {wr_lane, wr_area};
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    {rd_y, rd_x}       <= pos_mem[rd_addr];
    {rd_lane, rd_area} <= attr_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/nctm_isqrt.sv
// ----------------------------------------------------------------------------
// nctm_isqrt
// Bit-serial integer square root of (sq << 16), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nctm_isqrt (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [nctm_pkg::SQ_W-1:0]      sq,
  output logic                          done,
  output logic [nctm_pkg::DIST_W-1:0]   root
);
  import nctm_pkg::*;

  localparam int RAD_W = 2 * DIST_W;
  localparam int REM_W = DIST_W + 1;
  localparam int CW    = $clog2(DIST_W);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIST_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic              take;

  // One restoring step
  always_comb begin
    rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({root_r, 2'b01});
    take  = (rem_t >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIST_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'({sq, 16'b0});
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root_r <= {root_r[DIST_W-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: rtl/core/nctm_div.sv
// ----------------------------------------------------------------------------
// nctm_div
// Restoring divider: distance by the speed divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nctm_div (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [nctm_pkg::DIST_W-1:0]    num,
  input  wire [nctm_pkg::SDIV_W-1:0]    divisor,
  output logic                          done,
  output logic [nctm_pkg::DIST_W-1:0]   quo
);
  import nctm_pkg::*;

  localparam int CW = $clog2(DIST_W);

  logic [DIST_W-1:0] num_r;
  logic [SDIV_W-1:0] rem_r;
  logic [SDIV_W-1:0] div_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [SDIV_W:0]   rem_t;
  logic              take;

  always_comb begin
    rem_t = {rem_r, num_r[DIST_W-1]};
    take  = (rem_t >= {1'b0, div_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIST_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; a zero divisor counts as one
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      div_r <= (divisor == '0) ? SDIV_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= take ? SDIV_W'(rem_t - {1'b0, div_r}) : SDIV_W'(rem_t);
      num_r <= {num_r[DIST_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_centroid_track_matcher.sv
// Sequence (accept to out_tvalid): clear and ignored items go straight to the result; seed items
// and a match on an empty table insert a track first; other match items scan one track a cycle
// through a 3-stage compare, then insert (no candidate, or the gate rejects) or, when matched,
// update the track and run the square root and then the divide. An output stall holds the result.
// Throughput: one item at a time; the next is taken in the cycle after the result is queued.
// Reset: synchronous active-low; clears the track count and loads the registers.
// ----------------------------------------------------------------------------
// nearest_centroid_track_matcher
// Nearest centroid track table: seed, match-or-insert and clear operations.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_track_matcher #(
  parameter int MAX_TRACKS = nctm_pkg::MAX_TRACKS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // cfg
  input  wire                                cfg_we,
  input  wire                                cfg_index,
  input  wire [nctm_pkg::GATE_W-1:0]         cfg_wdata,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // center_x, center_y, box_height, box_area, lane, zero pad
  input  wire [nctm_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode
  input  wire [nctm_pkg::IN_USER_W-1:0]      in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // track_index, distance_q8, speed_q8, track_count, zero pad
  output logic [nctm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // matched, dropped
  output logic [nctm_pkg::OUT_USER_W-1:0]    out_tuser
);
  import nctm_pkg::*;

  localparam int AW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);

  // Configuration registers
  logic [GATE_W-1:0] gate_r;
  logic [SDIV_W-1:0] sdiv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r <= GATE_RST;
      sdiv_r <= SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GATE:  gate_r <= cfg_wdata;
        CFG_SPEED: sdiv_r <= cfg_wdata[SDIV_W-1:0];
        default:   ;
      endcase
    end
  end

  // Input field split
  logic [COORD_W-1:0] in_cx, in_cy, in_h;
  logic [AREA_W-1:0]  in_area;
  logic [LANE_W-1:0]  in_lane;
  op_t                in_op;
  logic               in_acc;

  assign in_cx   = in_tdata[10:0];
  assign in_cy   = in_tdata[21:11];
  assign in_h    = in_tdata[32:22];
  assign in_area = in_tdata[55:33];
  assign in_lane = in_tdata[58:56];
  assign in_op   = op_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;

  state_t state_r, state_nxt;

  // Item registers
  op_t                op_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [AREA_W-1:0]  area_r;
  logic [LANE_W-1:0]  lane_r;
  logic [GH_W-1:0]    gh_r;
  logic [GHSQ_W-1:0]  gh_sq_r;
  logic [CW-1:0]      used_r;

  // Scan pipeline
  logic [CW-1:0]      scan_cnt_r;
  logic               p1_vld_r, p2_vld_r, p3_vld_r;
  logic [AW-1:0]      p1_idx_r, p2_idx_r, p3_idx_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;
  logic               found_r;
  logic [AW-1:0]      best_idx_r;
  logic [SQ_W-1:0]    best_sq_r;

  // Result registers
  logic               matched_r, dropped_r;
  logic [AW-1:0]      idx_r;
  logic [DIST_W-1:0]  dist_r, speed_r;

  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  // Memory interface
  mem_we_t            mem_we;
  logic [AW-1:0]      mem_wr_addr;
  logic [AW-1:0]      mem_rd_addr;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic [AREA_W-1:0]  rd_area;
  logic [LANE_W-1:0]  rd_lane;

  logic               scan_issue, scan_done, gate_pass, table_full, out_free;
  logic               sq_done, div_done;
  logic [DIST_W-1:0]  sq_root, div_quo;
  logic [SQ_W-1:0]    s_sum;
  logic [COORD_W-1:0] dx_c, dy_c;

  assign scan_issue = (state_r == ST_SCAN) && (scan_cnt_r < used_r);
  assign scan_done  = !scan_issue && !p1_vld_r && !p2_vld_r && !p3_vld_r;
  assign gate_pass  = GHSQ_W'({best_sq_r, 4'b0}) < gh_sq_r;
  assign table_full = (used_r >= CW'(MAX_TRACKS));
  assign out_free   = !out_tvalid_r || out_tready;
  assign mem_rd_addr = scan_cnt_r[AW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            OP_MATCH: state_nxt = (used_r == '0) ? ST_INSERT : ST_SCAN;
            OP_SEED:  state_nxt = ST_INSERT;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN:   if (scan_done) state_nxt = found_r ? ST_GATE : ST_INSERT;
      ST_GATE:   state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = gate_pass ? ST_UPDATE : ST_INSERT;
      ST_UPDATE: state_nxt = ST_SQRT;
      ST_SQRT:   if (sq_done) state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_DONE;
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    mem_we.pos_we  = 1'b0;
    mem_we.attr_we = 1'b0;
    mem_wr_addr    = used_r[AW-1:0];
    case (state_r)
      ST_UPDATE: begin
        mem_we.pos_we = 1'b1;
        mem_wr_addr   = best_idx_r;
      end
      ST_INSERT: begin
        mem_we.pos_we  = !table_full;
        mem_we.attr_we = !table_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      cx_r   <= in_cx;
      cy_r   <= in_cy;
      area_r <= in_area;
      lane_r <= in_lane;
      gh_r   <= gate_r * in_h;
    end
    if (state_r == ST_GATE) begin
      gh_sq_r <= gh_r * gh_r;
    end
  end

  // Absolute differences on the read data and the sum of their squares
  always_comb begin
    dx_c = (cx_r > rd_x) ? cx_r - rd_x : rd_x - cx_r;
    dy_c = (cy_r > rd_y) ? cy_r - rd_y : rd_y - cy_r;
    s_sum = SQ_W'(sqx_r) + SQ_W'(sqy_r);
  end

  // Scan pipeline: issue, read, differences, squares, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      scan_cnt_r <= '0;
      found_r <= 1'b0;
    end else begin
      p1_vld_r <= scan_issue;
      p2_vld_r <= p1_vld_r && (rd_lane == lane_r) && (rd_area > area_r);
      p3_vld_r <= p2_vld_r;
      if (in_acc) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (scan_issue) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (p3_vld_r && (!found_r || s_sum < best_sq_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= mem_rd_addr;
    p2_idx_r <= p1_idx_r;
    p3_idx_r <= p2_idx_r;
    dx_r     <= dx_c;
    dy_r     <= dy_c;
    sqx_r    <= dx_r * dx_r;
    sqy_r    <= dy_r * dy_r;
    if (p3_vld_r && (!found_r || s_sum < best_sq_r)) begin
      best_sq_r  <= s_sum;
      best_idx_r <= p3_idx_r;
    end
  end

  // Track count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (state_r == ST_INSERT && !table_full) begin
      used_r <= used_r + 1'b1;
    end else if (state_r == ST_DONE && op_r == OP_CLEAR && out_free) begin
      used_r <= '0;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      matched_r <= 1'b0;
      dropped_r <= 1'b0;
      idx_r     <= '0;
      dist_r    <= '0;
      speed_r   <= '0;
    end else begin
      case (state_r)
        ST_UPDATE: begin
          matched_r <= 1'b1;
          idx_r     <= best_idx_r;
        end
        ST_INSERT: begin
          dropped_r <= table_full;
          idx_r     <= table_full ? '0 : used_r[AW-1:0];
        end
        ST_SQRT: if (sq_done) dist_r <= sq_root;
        ST_DIV:  if (div_done) speed_r <= div_quo;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_tdata_r <= OUT_DATA_W'({
        (op_r == OP_CLEAR) ? CNT_W'(0) : CNT_W'(used_r),
        speed_r, dist_r, IDX_W'(idx_r)});
      out_tuser_r <= {dropped_r, matched_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  nctm_track_mem #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_x    (cx_r),
    .wr_y    (cy_r),
    .wr_area (area_r),
    .wr_lane (lane_r),
    .rd_addr (mem_rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .rd_area (rd_area),
    .rd_lane (rd_lane)
  );

  nctm_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_UPDATE),
    .sq    (best_sq_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  nctm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_SQRT && sq_done),
    .num     (sq_root),
    .divisor (sdiv_r),
    .done    (div_done),
    .quo     (div_quo)
  );

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_TRACKS))
    else $error("track count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item accepted while previous item in flight");

  a_update_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we.pos_we && !mem_we.attr_we |-> (CW'(best_idx_r) < used_r) && found_r)
    else $error("position update outside valid tracks");

endmodule

`default_nettype wire
